// File: hw/rtl/cfd_pkg.sv
package cfd_pkg;

  localparam int IDX_W   = 21;
  localparam int CNT_W   = 20;
  localparam int CFG_W   = 21;
  localparam int OP_W    = 2;
  localparam int TAPI_W  = 8;
  localparam int COEF_W  = 24;
  localparam int SAMP_W  = 16;
  localparam int OUT_W   = 16;

  localparam logic [OP_W-1:0] OP_TAP     = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic REG_FIRST = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  localparam logic [CNT_W-1:0] COUNT_RESET = 20'd100000;

  localparam logic [OUT_W-1:0] OUT_MAX = 16'h7FFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 16'h8000;

  typedef struct packed {
    logic clear;
    logic shift;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic take;
    logic first;
    logic final_tap;
  } mac_req_t;

  typedef struct packed {
    logic done;
    logic emit;
    logic last;
  } win_res_t;

endpackage

// File: hw/rtl/cfd_cell.sv
module cfd_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfd_pkg::cell_ctl_t                    ctl,
  input  logic                                  coef_we,
  input  logic signed [cfd_pkg::COEF_W-1:0]     coef_wdata,
  input  logic signed [cfd_pkg::SAMP_W-1:0]     nbr_re,
  input  logic signed [cfd_pkg::SAMP_W-1:0]     nbr_im,
  input  logic signed [cfd_pkg::COEF_W-1:0]     nbr_coef,
  output logic signed [cfd_pkg::SAMP_W-1:0]     hist_re,
  output logic signed [cfd_pkg::SAMP_W-1:0]     hist_im,
  output logic signed [cfd_pkg::COEF_W-1:0]     coef
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      hist_re <= '0;
      hist_im <= '0;
    end else if (ctl.shift) begin
      hist_re <= nbr_re;
      hist_im <= nbr_im;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef <= coef_wdata;
    end else if (ctl.rotate) begin
      coef <= nbr_coef;
    end
  end

endmodule

// File: hw/rtl/cfd_win.sv
module cfd_win #(
  parameter int DECIMATION = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          ge,
  input  logic [cfd_pkg::IDX_W-1:0]     delta,
  input  logic [cfd_pkg::CNT_W-1:0]     count,
  output cfd_pkg::win_res_t             res
);

  localparam int SH = cfd_pkg::IDX_W + $clog2(DECIMATION);
  localparam int MW = cfd_pkg::IDX_W + 2;
  localparam int PW = cfd_pkg::IDX_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(DECIMATION) - 64'd1) / 64'(DECIMATION));
  localparam logic [cfd_pkg::IDX_W-1:0] DIV = cfd_pkg::IDX_W'(DECIMATION);

  logic                        busy;
  logic                        fin;
  logic                        ge_r;
  logic                        hit;
  logic [cfd_pkg::IDX_W-1:0]   dsh;
  logic [cfd_pkg::IDX_W-1:0]   quo;
  logic [PW-1:0]               prod;
  logic [cfd_pkg::IDX_W-1:0]   quo_next;
  logic [cfd_pkg::IDX_W-1:0]   rem_next;
  logic [cfd_pkg::IDX_W:0]     quo_inc;

  // divide by the constant decimation through a reciprocal multiply
  always_comb begin
    prod     = {{MW{1'b0}}, dsh} * {{cfd_pkg::IDX_W{1'b0}}, RECIP};
    quo_next = cfd_pkg::IDX_W'(prod >> SH);
    rem_next = dsh - quo_next * DIV;
    quo_inc  = {1'b0, quo} + (cfd_pkg::IDX_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      busy <= start;
      fin  <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ge_r <= ge;
      dsh  <= delta;
    end
    if (busy) begin
      quo <= quo_next;
      hit <= (rem_next == '0);
    end
  end

  always_comb begin
    res.done = fin;
    res.emit = ge_r && hit && (quo < {1'b0, count});
    res.last = (quo_inc == {2'b00, count});
  end

endmodule

// File: hw/rtl/cfd_mac.sv
module cfd_mac #(
  parameter int TAPS           = 129,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  cfd_pkg::mac_req_t                     req,
  input  logic signed [cfd_pkg::SAMP_W-1:0]     hist_re,
  input  logic signed [cfd_pkg::SAMP_W-1:0]     hist_im,
  input  logic signed [cfd_pkg::COEF_W-1:0]     coef,
  output logic                                  done,
  output logic [cfd_pkg::OUT_W-1:0]             res_re,
  output logic [cfd_pkg::OUT_W-1:0]             res_im
);

  localparam int PROD_W = cfd_pkg::SAMP_W + cfd_pkg::COEF_W;
  localparam int ACC_W  = PROD_W + $clog2(TAPS);
  localparam int QW     = ACC_W - COEF_FRAC_BITS;

  logic                       v1;
  logic                       first1;
  logic                       final1;
  logic signed [PROD_W-1:0]   prod_re;
  logic signed [PROD_W-1:0]   prod_im;
  logic signed [ACC_W-1:0]    acc_re;
  logic signed [ACC_W-1:0]    acc_im;
  logic                       fin2;
  logic [QW-1:0]              q_re;
  logic [QW-1:0]              q_im;
  logic                       inc_re;
  logic                       inc_im;
  logic                       fin3;

  function automatic logic round_up(input logic [ACC_W-1:0] a);
    logic [COEF_FRAC_BITS-1:0] rem;
    logic [COEF_FRAC_BITS-1:0] half;
    rem  = a[COEF_FRAC_BITS-1:0];
    half = {1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
    return (rem > half) || ((rem == half) && a[COEF_FRAC_BITS]);
  endfunction

  function automatic logic [cfd_pkg::OUT_W-1:0] saturate(input logic [QW-1:0] q,
                                                         input logic inc);
    logic [QW:0]                 s;
    logic [QW-cfd_pkg::OUT_W+1:0] hi;
    s  = {q[QW-1], q} + (QW+1)'(inc);
    hi = s[QW:cfd_pkg::OUT_W-1];
    if ((&hi) || !(|hi)) begin
      return s[cfd_pkg::OUT_W-1:0];
    end
    return s[QW] ? cfd_pkg::OUT_MIN : cfd_pkg::OUT_MAX;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      fin2 <= 1'b0;
      fin3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.take;
      fin2 <= v1 && final1;
      fin3 <= fin2;
      done <= fin3;
    end
  end

  always_ff @(posedge clk) begin
    first1  <= req.first;
    final1  <= req.final_tap;
    prod_re <= hist_re * coef;
    prod_im <= hist_im * coef;
    if (v1) begin
      acc_re <= first1 ? ACC_W'(prod_re) : acc_re + ACC_W'(prod_re);
      acc_im <= first1 ? ACC_W'(prod_im) : acc_im + ACC_W'(prod_im);
    end
    if (fin2) begin
      q_re   <= acc_re[ACC_W-1:COEF_FRAC_BITS];
      q_im   <= acc_im[ACC_W-1:COEF_FRAC_BITS];
      inc_re <= round_up(acc_re);
      inc_im <= round_up(acc_im);
    end
    if (fin3) begin
      res_re <= saturate(q_re, inc_re);
      res_im <= saturate(q_im, inc_im);
    end
  end

endmodule

// File: hw/rtl/complex_fir_decimator_top.sv
// Tap write and restart requests are done in ST_IDLE; a push moves to ST_CHECK
// and waits for the window unit (busy, then fin registers). A push that yields an
// output then passes ST_MAC, ST_DRAIN and ST_OUT before s_tready rises again,
// while the sample ring rotates once past one multiply-accumulate unit per rail;
// a result still held on the output stalls the next one until it is taken.
// Reset clears the sample ring, the sample index and the output register.
module complex_fir_decimator_top #(
  parameter int TAPS           = 129,
  parameter int DECIMATION     = 2,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [63:0]                   s_tdata,   // tap_index, tap_value, sample_re, sample_im
  input  logic [cfd_pkg::OP_W-1:0]      s_tuser,   // operation
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // out_re, out_im
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [cfd_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int TCW = $clog2(TAPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAC,
    ST_DRAIN,
    ST_OUT
  } state_t;

  state_t                              state;
  logic [TCW-1:0]                      tap_cnt;
  logic                                last_flag;
  logic [cfd_pkg::IDX_W-1:0]           sample_index;
  logic [cfd_pkg::IDX_W-1:0]           first_output_sample;
  logic [cfd_pkg::CNT_W-1:0]           output_count;

  logic                                req_acc;
  logic                                tap_acc;
  logic                                push_acc;
  logic                                restart_acc;
  logic                                rotate;
  cfd_pkg::cell_ctl_t                  ctl;
  cfd_pkg::mac_req_t                   mreq;
  cfd_pkg::win_res_t                   wres;
  logic                                mac_done;
  logic [cfd_pkg::OUT_W-1:0]           mac_re;
  logic [cfd_pkg::OUT_W-1:0]           mac_im;

  logic [cfd_pkg::TAPI_W-1:0]          tap_index;
  logic signed [cfd_pkg::COEF_W-1:0]   tap_value;
  logic signed [cfd_pkg::SAMP_W-1:0]   sample_re;
  logic signed [cfd_pkg::SAMP_W-1:0]   sample_im;

  logic signed [cfd_pkg::SAMP_W-1:0]   hist_re [TAPS];
  logic signed [cfd_pkg::SAMP_W-1:0]   hist_im [TAPS];
  logic signed [cfd_pkg::COEF_W-1:0]   coef    [TAPS];

  assign tap_index = s_tdata[7:0];
  assign tap_value = s_tdata[31:8];
  assign sample_re = s_tdata[47:32];
  assign sample_im = s_tdata[63:48];

  assign s_tready = (state == ST_IDLE);
  assign req_acc  = s_tvalid && s_tready;

  always_comb begin
    tap_acc     = 1'b0;
    push_acc    = 1'b0;
    restart_acc = 1'b0;
    unique case (s_tuser)
      cfd_pkg::OP_TAP:     tap_acc     = req_acc;
      cfd_pkg::OP_PUSH:    push_acc    = req_acc;
      cfd_pkg::OP_RESTART: restart_acc = req_acc;
      default: ;
    endcase
  end

  assign rotate = (state == ST_MAC);

  always_comb begin
    ctl.clear      = restart_acc;
    ctl.shift      = push_acc || rotate;
    ctl.rotate     = rotate;
    mreq.take      = rotate;
    mreq.first     = (tap_cnt == '0);
    mreq.final_tap = (tap_cnt == TCW'(TAPS - 1));
  end

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    logic signed [cfd_pkg::SAMP_W-1:0] nbr_re;
    logic signed [cfd_pkg::SAMP_W-1:0] nbr_im;
    logic signed [cfd_pkg::COEF_W-1:0] nbr_coef;
    if (k == TAPS - 1) begin : g_end
      assign nbr_re   = rotate ? hist_re[0] : sample_re;
      assign nbr_im   = rotate ? hist_im[0] : sample_im;
      assign nbr_coef = coef[0];
    end else begin : g_mid
      assign nbr_re   = hist_re[k+1];
      assign nbr_im   = hist_im[k+1];
      assign nbr_coef = coef[k+1];
    end
    cfd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .coef_we    (tap_acc && (tap_index == cfd_pkg::TAPI_W'(k))),
      .coef_wdata (tap_value),
      .nbr_re     (nbr_re),
      .nbr_im     (nbr_im),
      .nbr_coef   (nbr_coef),
      .hist_re    (hist_re[k]),
      .hist_im    (hist_im[k]),
      .coef       (coef[k])
    );
  end

  cfd_win #(
    .DECIMATION (DECIMATION)
  ) u_win (
    .clk   (clk),
    .rst   (rst),
    .start (push_acc),
    .ge    (sample_index >= first_output_sample),
    .delta (sample_index - first_output_sample),
    .count (output_count),
    .res   (wres)
  );

  cfd_mac #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .req     (mreq),
    .hist_re (hist_re[0]),
    .hist_im (hist_im[0]),
    .coef    (coef[0]),
    .done    (mac_done),
    .res_re  (mac_re),
    .res_im  (mac_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_output_sample <= '0;
      output_count        <= cfd_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfd_pkg::REG_FIRST: first_output_sample <= cfg_wdata;
        cfd_pkg::REG_COUNT: output_count        <= cfg_wdata[cfd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      sample_index <= '0;
      tap_cnt      <= '0;
      last_flag    <= 1'b0;
      m_tvalid     <= 1'b0;
      m_tlast      <= 1'b0;
      m_tdata      <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (restart_acc) begin
            sample_index <= '0;
          end else if (push_acc) begin
            sample_index <= sample_index + cfd_pkg::IDX_W'(1);
            state        <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (wres.done) begin
            if (wres.emit) begin
              last_flag <= wres.last;
              tap_cnt   <= '0;
              state     <= ST_MAC;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_MAC: begin
          tap_cnt <= tap_cnt + TCW'(1);
          if (mreq.final_tap) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (mac_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {mac_im, mac_re};
            m_tlast  <= last_flag;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: sim/complex_fir_decimator_top_test.sv
`timescale 1ns / 1ps

import cfd_pkg::*;

typedef struct packed {
  logic signed [OUT_W-1:0] re;
  logic signed [OUT_W-1:0] im;
  logic                    last;
} fir_output_t;

class fir_scoreboard;
  localparam int N_TAPS = 129;
  localparam int DECIM  = 2;
  localparam int FRAC   = 16;

  logic signed [SAMP_W-1:0] hist_re [N_TAPS];
  logic signed [SAMP_W-1:0] hist_im [N_TAPS];
  logic signed [COEF_W-1:0] coef [N_TAPS];
  logic [IDX_W-1:0]         sample_idx;
  logic [IDX_W-1:0]         first_out;
  logic [CNT_W-1:0]         out_count;
  fir_output_t              pending_q [$];
  int errors;
  int n_push, n_tap, n_restart, n_ignored, n_results, n_sat;

  function new();
    for (int k = 0; k < N_TAPS; k++) begin
      hist_re[k] = '0;
      hist_im[k] = '0;
      coef[k] = '0;
    end
    sample_idx = '0;
    first_out = '0;
    out_count = COUNT_RESET;
    errors = 0;
    n_push = 0;
    n_tap = 0;
    n_restart = 0;
    n_ignored = 0;
    n_results = 0;
    n_sat = 0;
  endfunction

  function void write_reg(logic index, logic [CFG_W-1:0] value);
    if (index == REG_FIRST) first_out = value;
    else out_count = value[CNT_W-1:0];
  endfunction

  function logic signed [OUT_W-1:0] round_sat(longint acc);
    longint q;
    logic [FRAC-1:0] rem;
    q = acc >>> FRAC;
    rem = acc[FRAC-1:0];
    if (rem > (1 << (FRAC - 1)) || (rem == (1 << (FRAC - 1)) && q[0])) q++;
    if (q > 32767) begin
      q = 32767;
      n_sat++;
    end else if (q < -32768) begin
      q = -32768;
      n_sat++;
    end
    return q[OUT_W-1:0];
  endfunction

  function void note_request(logic [OP_W-1:0] op, logic [63:0] data);
    logic [TAPI_W-1:0] k;
    logic [IDX_W-1:0] s;
    logic [IDX_W-1:0] d;
    longint acc_re;
    longint acc_im;
    fir_output_t r;
    case (op)
      OP_TAP: begin
        n_tap++;
        k = data[7:0];
        if (k < N_TAPS) coef[k] = data[31:8];
      end
      OP_RESTART: begin
        n_restart++;
        for (int i = 0; i < N_TAPS; i++) begin
          hist_re[i] = '0;
          hist_im[i] = '0;
        end
        sample_idx = '0;
      end
      OP_PUSH: begin
        n_push++;
        for (int i = 0; i < N_TAPS - 1; i++) begin
          hist_re[i] = hist_re[i+1];
          hist_im[i] = hist_im[i+1];
        end
        hist_re[N_TAPS-1] = data[47:32];
        hist_im[N_TAPS-1] = data[63:48];
        s = sample_idx;
        sample_idx = sample_idx + 1'b1;
        if (s >= first_out) begin
          d = s - first_out;
          if (d % DECIM == 0 && d / DECIM < out_count) begin
            acc_re = 0;
            acc_im = 0;
            for (int i = 0; i < N_TAPS; i++) begin
              acc_re += longint'(hist_re[i]) * longint'(coef[i]);
              acc_im += longint'(hist_im[i]) * longint'(coef[i]);
            end
            r.re = round_sat(acc_re);
            r.im = round_sat(acc_im);
            r.last = (d / DECIM + 1 == out_count);
            pending_q.push_back(r);
          end
        end
      end
      default: n_ignored++;
    endcase
  endfunction

  task report(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task check_result(logic [31:0] data, logic last);
    fir_output_t r;
    n_results++;
    if (pending_q.size() == 0) begin
      report($sformatf("output %h last %b with no request pending", data, last));
    end else begin
      r = pending_q.pop_front();
      if (data[15:0] !== r.re)
        report($sformatf("out_re %0d, expected %0d", $signed(data[15:0]), r.re));
      if (data[31:16] !== r.im)
        report($sformatf("out_im %0d, expected %0d", $signed(data[31:16]), r.im));
      if (last !== r.last)
        report($sformatf("last %b, expected %b", last, r.last));
    end
  endtask
endclass

module complex_fir_decimator_top_test;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 3000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [63:0]       s_tdata = '0;
  logic [OP_W-1:0]   s_tuser = OP_TAP;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;
  logic              m_tlast;
  logic              cfg_we = 1'b0;
  logic              cfg_index = REG_FIRST;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  fir_scoreboard sb = new();
  int  burst_left = 0;
  int  n_settings = 0;
  bit  hold_request = 1'b0;

  complex_fir_decimator_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
    end
  end

  initial begin : receiver
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk) m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (tick % 3 == 0);
          default: m_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Timeout with %0d outputs still pending", sb.pending_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [63:0] pack_request(logic [TAPI_W-1:0] idx, logic [COEF_W-1:0] val,
                                                logic [SAMP_W-1:0] re, logic [SAMP_W-1:0] im);
    return {im, re, val, idx};
  endfunction

  task automatic send_request(logic [OP_W-1:0] op, logic [63:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk) s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic tap_write(logic [TAPI_W-1:0] idx, logic [COEF_W-1:0] val);
    send_request(OP_TAP, pack_request(idx, val, 16'($urandom), 16'($urandom)));
  endtask

  task automatic push(logic [SAMP_W-1:0] re, logic [SAMP_W-1:0] im);
    send_request(OP_PUSH, pack_request(8'($urandom), 24'($urandom), re, im));
  endtask

  task automatic go_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(logic index, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(negedge clk) cfg_we <= 1'b0;
    sb.write_reg(index, value);
  endtask

  function automatic logic [SAMP_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 200) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] random_coef();
    case ($urandom_range(0, 31))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom);
      default: return 24'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 76) begin
      push(random_sample(), random_sample());
    end else if (pick < 88) begin
      if ($urandom_range(0, 9) == 0) tap_write(8'($urandom_range(129, 255)), random_coef());
      else tap_write(8'($urandom_range(0, 128)), random_coef());
    end else if (pick < 96) begin
      send_request(OP_RESTART, 64'({$urandom, $urandom}));
    end else begin
      send_request(OP_UNUSED, 64'({$urandom, $urandom}));
    end
  endtask

  logic [CFG_W-1:0] first_tab [7] = '{0, 0, 21'h1FFFFF, 3, 0, 0, 1};
  logic [CFG_W-1:0] count_tab [7] = '{1, 0, 21'hFFFFF, 5, 0, 21'hFFFFF, 40};

  initial begin
    logic [CFG_W-1:0] first_val;
    logic [CFG_W-1:0] count_val;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    for (int k = 0; k < 129; k++) tap_write(8'(k), (k == 128) ? 24'h008000 : 24'h0);
    tap_write(8'd129, 24'h7FFFFF);
    tap_write(8'd255, 24'h800000);
    send_request(OP_UNUSED, 64'({$urandom, $urandom}));
    push(16'd1, -16'sd1);
    push(16'd7, 16'd7);
    push(16'd3, -16'sd3);
    push(16'd0, 16'd0);
    push(16'd5, -16'sd5);
    tap_write(8'd128, 24'h7FFFFF);
    tap_write(8'd0, 24'h800000);
    push(16'h7FFF, 16'h8000);
    push(16'h7FFF, 16'h8000);
    send_request(OP_RESTART, 64'({$urandom, $urandom}));
    push(16'h8000, 16'h7FFF);
    for (int k = 0; k < 129; k++) tap_write(8'(k), 24'($urandom_range(0, 4095) - 2048));
    go_idle();

    for (int p = 0; p < 7; p++) begin
      first_val = first_tab[p];
      count_val = count_tab[p];
      if (p == 4) begin
        first_val = CFG_W'($urandom_range(0, 40));
        count_val = CFG_W'($urandom_range(1, 30));
      end
      set_register(REG_FIRST, first_val);
      set_register(REG_COUNT, count_val);
      n_settings++;
      if (p == 5) hold_request = 1'b1;
      send_request(OP_RESTART, 64'({$urandom, $urandom}));
      repeat (110) random_request();
      go_idle();
    end

    $display("Sent %0d pushes, %0d tap writes, %0d restarts, %0d unused codes",
             sb.n_push, sb.n_tap, sb.n_restart, sb.n_ignored);
    $display("Checked %0d outputs (%0d saturated rails) across %0d window settings",
             sb.n_results, sb.n_sat, n_settings + 1);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: complex_fir_decimator_top.f
hw/rtl/cfd_pkg.sv
hw/rtl/cfd_cell.sv
hw/rtl/cfd_win.sv
hw/rtl/cfd_mac.sv
hw/rtl/complex_fir_decimator_top.sv
sim/complex_fir_decimator_top_test.sv
